// ===== hw/rtl/mandelbrot_image_orbit_trap_assert.svh =====
// assertion macros for the orbit trap renderer
`ifndef MANDELBROT_IMAGE_ORBIT_TRAP_ASSERT_SVH
`define MANDELBROT_IMAGE_ORBIT_TRAP_ASSERT_SVH

// property checked at every clock edge outside reset
`define MBOT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define MBOT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/mbot_pkg.sv =====
`default_nettype none

package mbot_pkg;

  localparam int ImgW      = 512;
  localparam int ImgH      = 512;
  localparam int IterLimit = 1000;
  localparam int FracBits  = 27;

  localparam int CfgFrac   = 27;
  localparam int CfgW      = 32;
  localparam int CfgIdxW   = 3;
  localparam int StepRegW  = CfgW - 1;
  localparam int ScaleW    = 32;
  localparam int ScaleFrac = 20;
  localparam int PosW      = 9;
  localparam int ChanW     = 8;
  localparam int ColW      = 3 * ChanW;

  localparam int DpW       = FracBits + 5;
  localparam int ShUp      = (FracBits >= CfgFrac) ? FracBits - CfgFrac : 0;
  localparam int ShDn      = (FracBits < CfgFrac) ? CfgFrac - FracBits : 0;
  localparam int StepW     = DpW - 1;
  localparam int MapW      = DpW + PosW + 1;
  localparam int SqW       = 2 * DpW - FracBits;
  localparam int SumW      = SqW + 2;
  localparam int SatW      = (MapW > SumW) ? MapW : SumW;
  localparam int DiffW     = DpW + 1;
  localparam int TrapProdW = DiffW + ScaleW + 1;
  localparam int TrapSh    = FracBits + ScaleFrac;
  localparam int TxW       = TrapProdW - TrapSh;

  localparam int TrapDepth = ImgW * ImgH;
  localparam int AddrW     = $clog2(TrapDepth);
  localparam int XW        = $clog2(ImgW);
  localparam int YW        = $clog2(ImgH);
  localparam int IterW     = $clog2(IterLimit + 1);

  localparam logic signed [SqW:0] Four = (SqW + 1)'(4) << FracBits;
  localparam logic signed [TrapProdW-1:0] TrapBias =
    {{(TrapProdW - TrapSh){1'b0}}, {TrapSh{1'b1}}};

  localparam logic [CfgW-1:0]     ResetOrigin = 32'hE800_0000;
  localparam logic [StepRegW-1:0] ResetStep   = 31'h0018_0000;
  localparam logic [ScaleW-1:0]   ResetScale  = 32'h0555_5555;
  localparam logic [ColW-1:0]     BgColour    = 24'h33_BE_C3;
  localparam logic [ChanW-1:0]    ChanFull    = 8'hFF;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PLANE_REAL_ORIGIN = 3'd0,
    REG_PLANE_IMAG_ORIGIN = 3'd1,
    REG_STEP_REAL         = 3'd2,
    REG_STEP_IMAG         = 3'd3,
    REG_TRAP_REAL_ORIGIN  = 3'd4,
    REG_TRAP_IMAG_ORIGIN  = 3'd5,
    REG_TRAP_SCALE_REAL   = 3'd6,
    REG_TRAP_SCALE_IMAG   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic             command;
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [ChanW-1:0] texel_red;
    logic [ChanW-1:0] texel_green;
    logic [ChanW-1:0] texel_blue;
  } req_t;

  typedef struct packed {
    logic [PosW-1:0]  pixel_x;
    logic [PosW-1:0]  pixel_y;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             was_trapped;
  } rsp_t;

  typedef struct packed {
    logic signed [CfgW-1:0] plane_real_origin;
    logic signed [CfgW-1:0] plane_imag_origin;
    logic [StepRegW-1:0]    step_real;
    logic [StepRegW-1:0]    step_imag;
    logic signed [CfgW-1:0] trap_real_origin;
    logic signed [CfgW-1:0] trap_imag_origin;
    logic [ScaleW-1:0]      trap_scale_real;
    logic [ScaleW-1:0]      trap_scale_imag;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic signed [DpW-1:0] zr;
    logic signed [DpW-1:0] zi;
  } orbit_t;

  typedef struct packed {
    logic            valid;
    logic [ColW-1:0] colour;
  } hit_t;

  function automatic logic signed [DpW-1:0] to_dp(input logic signed [CfgW-1:0] v);
    logic signed [63:0] w;
    w = longint'(v);
    w = (w <<< ShUp) >>> ShDn;
    return DpW'(w);
  endfunction

  function automatic logic [StepW-1:0] step_dp(input logic [StepRegW-1:0] s);
    logic [63:0] w;
    w = 64'(s);
    w = (w << ShUp) >> ShDn;
    return StepW'(w);
  endfunction

  function automatic logic signed [DpW-1:0] saturate(input logic signed [SatW-1:0] v);
    logic signed [DpW-1:0] r;
    if (v[SatW-1:DpW-1] == '0 || v[SatW-1:DpW-1] == '1) begin
      r = v[DpW-1:0];
    end else if (v[SatW-1]) begin
      r = {1'b1, {(DpW - 1){1'b0}}};
    end else begin
      r = {1'b0, {(DpW - 1){1'b1}}};
    end
    return r;
  endfunction

  // integer part, rounded toward zero
  function automatic logic signed [TxW-1:0] trap_trunc(input logic signed [TrapProdW-1:0] p);
    logic signed [TrapProdW-1:0] b;
    b = p;
    if (p[TrapProdW-1]) begin
      b = p + TrapBias;
    end
    return b[TrapProdW-1:TrapSh];
  endfunction

  function automatic logic [AddrW-1:0] texel_addr(input logic [XW-1:0] x,
                                                  input logic [YW-1:0] y);
    return AddrW'(y) * AddrW'(ImgW) + AddrW'(x);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mbot_cfg.sv =====
`default_nettype none

module mbot_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbot_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mbot_pkg::CfgW-1:0]     cfg_data_i,
  output mbot_pkg::cfg_t                cfg_o
);

  mbot_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plane_real_origin <= mbot_pkg::ResetOrigin;
      cfg_q.plane_imag_origin <= mbot_pkg::ResetOrigin;
      cfg_q.step_real         <= mbot_pkg::ResetStep;
      cfg_q.step_imag         <= mbot_pkg::ResetStep;
      cfg_q.trap_real_origin  <= mbot_pkg::ResetOrigin;
      cfg_q.trap_imag_origin  <= mbot_pkg::ResetOrigin;
      cfg_q.trap_scale_real   <= mbot_pkg::ResetScale;
      cfg_q.trap_scale_imag   <= mbot_pkg::ResetScale;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mbot_pkg::REG_PLANE_REAL_ORIGIN: begin
          cfg_q.plane_real_origin <= cfg_data_i;
        end
        mbot_pkg::REG_PLANE_IMAG_ORIGIN: begin
          cfg_q.plane_imag_origin <= cfg_data_i;
        end
        mbot_pkg::REG_STEP_REAL: begin
          cfg_q.step_real <= cfg_data_i[mbot_pkg::StepRegW-1:0];
        end
        mbot_pkg::REG_STEP_IMAG: begin
          cfg_q.step_imag <= cfg_data_i[mbot_pkg::StepRegW-1:0];
        end
        mbot_pkg::REG_TRAP_REAL_ORIGIN: begin
          cfg_q.trap_real_origin <= cfg_data_i;
        end
        mbot_pkg::REG_TRAP_IMAG_ORIGIN: begin
          cfg_q.trap_imag_origin <= cfg_data_i;
        end
        mbot_pkg::REG_TRAP_SCALE_REAL: begin
          cfg_q.trap_scale_real <= cfg_data_i;
        end
        mbot_pkg::REG_TRAP_SCALE_IMAG: begin
          cfg_q.trap_scale_imag <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mbot_trap_ram.sv =====
`default_nettype none

module mbot_trap_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [mbot_pkg::AddrW-1:0]  waddr_i,
  input  logic [mbot_pkg::ColW-1:0]   wdata_i,
  input  logic                        re_i,
  input  logic [mbot_pkg::AddrW-1:0]  raddr_i,
  output logic [mbot_pkg::ColW-1:0]   rdata_o
);

  logic [mbot_pkg::ColW-1:0] mem [mbot_pkg::TrapDepth];
  logic [mbot_pkg::ColW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mbot_orbit.sv =====
`default_nettype none

module mbot_orbit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mbot_pkg::cfg_t             cfg_i,
  input  logic                       start_i,
  input  logic [mbot_pkg::PosW-1:0]  px_i,
  input  logic [mbot_pkg::PosW-1:0]  py_i,
  input  logic                       kill_i,
  output mbot_pkg::orbit_t           orbit_o,
  output logic                       finished_o
);

  typedef enum logic [3:0] {
    OB_IDLE = 4'b0001,
    OB_MAP  = 4'b0010,
    OB_MUL  = 4'b0100,
    OB_ADD  = 4'b1000
  } ob_state_e;

  ob_state_e state_q, state_d;

  logic [mbot_pkg::PosW-1:0]        px_q, py_q;
  logic signed [mbot_pkg::DpW-1:0]  cr_q, ci_q, zr_q, zi_q;
  logic signed [mbot_pkg::SqW-1:0]  rsq_q, isq_q, cross_q;
  logic [mbot_pkg::IterW-1:0]       cnt_q;
  logic                             push_q;

  logic [mbot_pkg::PosW+mbot_pkg::StepW-1:0] xoff, yoff;
  logic signed [mbot_pkg::MapW-1:0]          cr_map, ci_map;
  logic signed [2*mbot_pkg::DpW-1:0]         p_rr, p_ii, p_ri;
  logic signed [mbot_pkg::SqW:0]             mag;
  logic signed [mbot_pkg::SumW-1:0]          zr_sum, zi_sum;
  logic signed [mbot_pkg::DpW-1:0]           zr_new, zi_new;
  logic                                      escape, last;

  // point of the plane for this pixel
  assign xoff   = px_q * mbot_pkg::step_dp(cfg_i.step_real);
  assign yoff   = py_q * mbot_pkg::step_dp(cfg_i.step_imag);
  assign cr_map = mbot_pkg::MapW'(mbot_pkg::to_dp(cfg_i.plane_real_origin))
                + mbot_pkg::MapW'(xoff);
  assign ci_map = mbot_pkg::MapW'(mbot_pkg::to_dp(cfg_i.plane_imag_origin))
                + mbot_pkg::MapW'(yoff);

  assign p_rr = zr_q * zr_q;
  assign p_ii = zi_q * zi_q;
  assign p_ri = zr_q * zi_q;

  assign mag    = (mbot_pkg::SqW + 1)'(rsq_q) + (mbot_pkg::SqW + 1)'(isq_q);
  assign escape = mag > mbot_pkg::Four;
  assign last   = cnt_q == mbot_pkg::IterW'(mbot_pkg::IterLimit - 1);
  assign zr_sum = mbot_pkg::SumW'(rsq_q) - mbot_pkg::SumW'(isq_q) + mbot_pkg::SumW'(cr_q);
  assign zi_sum = (mbot_pkg::SumW'(cross_q) <<< 1) + mbot_pkg::SumW'(ci_q);
  assign zr_new = mbot_pkg::saturate(mbot_pkg::SatW'(zr_sum));
  assign zi_new = mbot_pkg::saturate(mbot_pkg::SatW'(zi_sum));

  always_comb begin
    state_d = state_q;
    case (state_q)
      OB_IDLE: begin
        if (start_i) begin
          state_d = OB_MAP;
        end
      end
      OB_MAP: begin
        state_d = OB_MUL;
      end
      OB_MUL: begin
        state_d = OB_ADD;
      end
      OB_ADD: begin
        state_d = (escape || last) ? OB_IDLE : OB_MUL;
      end
      default: begin
        state_d = OB_IDLE;
      end
    endcase
    if (kill_i) begin
      state_d = OB_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OB_IDLE;
      push_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      push_q  <= (state_q == OB_ADD) && !escape && !kill_i;
      if (state_q == OB_MAP) begin
        cnt_q <= '0;
      end else if (state_q == OB_ADD && !escape) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == OB_IDLE && start_i) begin
      px_q <= px_i;
      py_q <= py_i;
    end
    if (state_q == OB_MAP) begin
      cr_q <= mbot_pkg::saturate(mbot_pkg::SatW'(cr_map));
      ci_q <= mbot_pkg::saturate(mbot_pkg::SatW'(ci_map));
      zr_q <= mbot_pkg::saturate(mbot_pkg::SatW'(cr_map));
      zi_q <= mbot_pkg::saturate(mbot_pkg::SatW'(ci_map));
    end
    if (state_q == OB_MUL) begin
      rsq_q   <= p_rr[2*mbot_pkg::DpW-1:mbot_pkg::FracBits];
      isq_q   <= p_ii[2*mbot_pkg::DpW-1:mbot_pkg::FracBits];
      cross_q <= p_ri[2*mbot_pkg::DpW-1:mbot_pkg::FracBits];
    end
    if (state_q == OB_ADD && !escape) begin
      zr_q <= zr_new;
      zi_q <= zi_new;
    end
  end

  assign orbit_o    = '{valid: push_q, zr: zr_q, zi: zi_q};
  assign finished_o = (state_q == OB_IDLE) && !push_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mbot_lookup.sv =====
`default_nettype none

module mbot_lookup (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mbot_pkg::cfg_t              cfg_i,
  input  mbot_pkg::orbit_t            orbit_i,
  input  logic                        flush_i,
  output logic                        rd_en_o,
  output logic [mbot_pkg::AddrW-1:0]  rd_addr_o,
  input  logic [mbot_pkg::ColW-1:0]   rd_data_i,
  output mbot_pkg::hit_t              hit_o,
  output logic                        busy_o
);

  localparam int CW = mbot_pkg::ChanW;

  logic                                     v1_q, v2_q, v3_q, rd_v_q;
  logic signed [mbot_pkg::DiffW-1:0]        dx_q, dy_q, dx_d, dy_d;
  logic signed [mbot_pkg::TrapProdW-1:0]    pr_q, pi_q, pr_d, pi_d;
  logic signed [mbot_pkg::TxW-1:0]          tx, ty;
  logic [mbot_pkg::XW-1:0]                  tx_q;
  logic [mbot_pkg::YW-1:0]                  ty_q;
  logic signed [mbot_pkg::ScaleW:0]         scr, sci;
  logic                                     in_range, opaque;

  assign dx_d = mbot_pkg::DiffW'(orbit_i.zr)
              - mbot_pkg::DiffW'(mbot_pkg::to_dp(cfg_i.trap_real_origin));
  assign dy_d = mbot_pkg::DiffW'(orbit_i.zi)
              - mbot_pkg::DiffW'(mbot_pkg::to_dp(cfg_i.trap_imag_origin));

  assign scr  = {1'b0, cfg_i.trap_scale_real};
  assign sci  = {1'b0, cfg_i.trap_scale_imag};
  assign pr_d = dx_q * scr;
  assign pi_d = dy_q * sci;

  assign tx = mbot_pkg::trap_trunc(pr_q);
  assign ty = mbot_pkg::trap_trunc(pi_q);
  assign in_range = !tx[mbot_pkg::TxW-1] && (tx < mbot_pkg::TxW'(mbot_pkg::ImgW))
                 && !ty[mbot_pkg::TxW-1] && (ty < mbot_pkg::TxW'(mbot_pkg::ImgH));

  assign rd_en_o   = v3_q;
  assign rd_addr_o = mbot_pkg::texel_addr(tx_q, ty_q);

  // any saturated channel makes the texel transparent
  assign opaque = (rd_data_i[3*CW-1:2*CW] != mbot_pkg::ChanFull)
               && (rd_data_i[2*CW-1:CW] != mbot_pkg::ChanFull)
               && (rd_data_i[CW-1:0] != mbot_pkg::ChanFull);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      rd_v_q <= 1'b0;
    end else if (flush_i) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      rd_v_q <= 1'b0;
    end else begin
      v1_q   <= orbit_i.valid;
      v2_q   <= v1_q;
      v3_q   <= v2_q && in_range;
      rd_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
    pr_q <= pr_d;
    pi_q <= pi_d;
    tx_q <= tx[mbot_pkg::XW-1:0];
    ty_q <= ty[mbot_pkg::YW-1:0];
  end

  assign hit_o  = '{valid: rd_v_q && opaque, colour: rd_data_i};
  assign busy_o = v1_q || v2_q || v3_q || rd_v_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mandelbrot_image_orbit_trap.sv =====
// Mandelbrot orbit-trap renderer. A write request stores one 24-bit texel of the 512 x 512
// trap image in a single-port-write, single-port-read memory and gives no result; texels
// that were never written read as undefined, and there is no clearing pass. A render request
// maps its pixel to c, runs z = z*z + c up to 1000 times and looks each new z up in the trap
// image; it gives one result with the first opaque texel or the background colour. Each
// iteration of the z recurrence forms registered products, then adds and saturates, and the
// trap lookup trails it in a four-stage pipeline. One render is in flight at a time; a
// finished result waits in the output register while the next request is taken.
// Configuration writes take effect at once and are to be made by the user only while no
// render is in flight; the block itself does not enforce this.
`default_nettype none
`include "mandelbrot_image_orbit_trap_assert.svh"

module mandelbrot_image_orbit_trap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mbot_pkg::req_t                in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mbot_pkg::rsp_t                out_rsp_o,
  input  logic                          cfg_we_i,
  input  logic [mbot_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mbot_pkg::CfgW-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  mbot_pkg::cfg_t   cfg;
  mbot_pkg::orbit_t orbit;
  mbot_pkg::hit_t   hit;
  mbot_pkg::rsp_t   out_q;

  logic                         orbit_fin, lk_busy, kill, fin;
  logic                         in_acc, is_render, start, ram_we, out_free;
  logic                         rd_en;
  logic [mbot_pkg::AddrW-1:0]   rd_addr, wr_addr;
  logic [mbot_pkg::ColW-1:0]    rd_data, colour_q;
  logic [mbot_pkg::PosW-1:0]    px_q, py_q;
  logic                         trapped_q, out_valid_q;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_render  = in_req_i.command == mbot_pkg::CMD_RENDER;
  assign start      = in_acc && is_render;
  assign ram_we     = in_acc && !is_render
                   && (int'(in_req_i.pos_x) < mbot_pkg::ImgW)
                   && (int'(in_req_i.pos_y) < mbot_pkg::ImgH);
  assign wr_addr    = mbot_pkg::texel_addr(mbot_pkg::XW'(in_req_i.pos_x),
                                           mbot_pkg::YW'(in_req_i.pos_y));
  assign kill       = (state_q == ST_RUN) && hit.valid;
  assign fin        = orbit_fin && !lk_busy;
  assign out_free   = !out_valid_q || out_ready_i;

  mbot_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mbot_orbit u_orbit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .start_i    (start),
    .px_i       (in_req_i.pos_x),
    .py_i       (in_req_i.pos_y),
    .kill_i     (kill),
    .orbit_o    (orbit),
    .finished_o (orbit_fin)
  );

  mbot_lookup u_lookup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .orbit_i   (orbit),
    .flush_i   (kill),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .hit_o     (hit),
    .busy_o    (lk_busy)
  );

  mbot_trap_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i ({in_req_i.texel_red, in_req_i.texel_green, in_req_i.texel_blue}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (hit.valid || fin) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      px_q <= in_req_i.pos_x;
      py_q <= in_req_i.pos_y;
    end
    if (state_q == ST_RUN) begin
      if (hit.valid) begin
        colour_q  <= hit.colour;
        trapped_q <= 1'b1;
      end else if (fin) begin
        colour_q  <= mbot_pkg::BgColour;
        trapped_q <= 1'b0;
      end
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= '{pixel_x:     px_q,
                 pixel_y:     py_q,
                 out_red:     colour_q[3*mbot_pkg::ChanW-1:2*mbot_pkg::ChanW],
                 out_green:   colour_q[2*mbot_pkg::ChanW-1:mbot_pkg::ChanW],
                 out_blue:    colour_q[mbot_pkg::ChanW-1:0],
                 was_trapped: trapped_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `MBOT_ASSERT(a_hit_in_run, hit.valid |-> state_q == ST_RUN, "trap hit outside a render")
  `MBOT_ASSERT(a_push_in_run, orbit.valid |-> state_q == ST_RUN, "orbit step outside a render")
  `MBOT_ASSERT(a_done_quiet, state_q == ST_DONE |-> fin, "datapath still busy at render end")
  `MBOT_ASSERT_NEVER(a_ready_busy, in_ready_o && !fin, "request taken while datapath busy")

endmodule

`default_nettype wire
